@@ hdl/gcrs_pkg.sv @@
// Shared constants, types and helpers for the graph cut rank sampler.
package gcrs_pkg;

  // Graph size and block grouping
  localparam int VERTICES    = 12;
  localparam int BLOCK_SIZE  = 2;
  localparam int NUM_BLOCKS  = 5;
  localparam int NUM_SUBSETS = (1 << NUM_BLOCKS) - 1;

  // Derived widths
  localparam int VERT_W   = $clog2(VERTICES);
  localparam int RANK_W   = $clog2(VERTICES + 1);
  localparam int SUBSET_W = NUM_BLOCKS;
  localparam int CUT_W    = 5;
  localparam int OUT_RANK_W   = 3;
  localparam int OUT_RANK_MAX = (1 << OUT_RANK_W) - 1;

  // Generator
  localparam int SEED_W = 64;
  localparam logic [SEED_W-1:0] SEED_RESET = 64'd1;
  localparam int XS_A = 13;
  localparam int XS_B = 7;
  localparam int XS_C = 17;

  typedef logic [VERTICES-1:0] row_t;

  // Command bundle from the sequencer to the datapath
  typedef struct packed {
    logic                clear_adj;
    logic                gen_step;
    logic [VERT_W-1:0]   pair_i;
    logic [VERT_W-1:0]   pair_j;
    logic                load;
    logic                elim_step;
    logic [VERT_W-1:0]   col;
    logic [SUBSET_W-1:0] subset;
  } gcrs_cmd_t;

  // One xorshift64 step
  function automatic logic [SEED_W-1:0] xs_next(input logic [SEED_W-1:0] s);
    logic [SEED_W-1:0] t;
    t = s ^ (s << XS_A);
    t = t ^ (t >> XS_B);
    t = t ^ (t << XS_C);
    return t;
  endfunction

endpackage

@@ hdl/gcrs_ctrl.sv @@
// Sequencer: edge generation sweep, per-subset load / eliminate / emit.
module gcrs_ctrl
  import gcrs_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                in_sample_request,
  output logic                busy,
  output gcrs_cmd_t           cmd,
  output logic                out_valid,
  output logic [CUT_W-1:0]    out_cut_index,
  output logic                out_last_of_sample
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_GEN  = 5'b00010,
    ST_LOAD = 5'b00100,
    ST_ELIM = 5'b01000,
    ST_EMIT = 5'b10000
  } gcrs_state_t;

  gcrs_state_t         state_r, state_nxt;
  logic [VERT_W-1:0]   pi_r, pi_nxt;
  logic [VERT_W-1:0]   pj_r, pj_nxt;
  logic [VERT_W-1:0]   col_r, col_nxt;
  logic [SUBSET_W-1:0] sub_r, sub_nxt;
  logic                go;
  logic                last_pair;
  logic                last_sub;

  assign go        = start && !busy && in_sample_request;
  assign last_pair = (pi_r == VERT_W'(VERTICES - 2)) && (pj_r == VERT_W'(VERTICES - 1));
  assign last_sub  = (sub_r == SUBSET_W'(NUM_SUBSETS));

  // Next state and counters
  always_comb begin
    state_nxt = state_r;
    pi_nxt    = pi_r;
    pj_nxt    = pj_r;
    col_nxt   = col_r;
    sub_nxt   = sub_r;
    unique case (state_r)
      ST_IDLE: begin
        if (go) begin
          state_nxt = ST_GEN;
          pi_nxt    = '0;
          pj_nxt    = VERT_W'(1);
        end
      end
      ST_GEN: begin
        if (last_pair) begin
          state_nxt = ST_LOAD;
          sub_nxt   = SUBSET_W'(1);
        end else if (pj_r == VERT_W'(VERTICES - 1)) begin
          pi_nxt = pi_r + VERT_W'(1);
          pj_nxt = pi_r + VERT_W'(2);
        end else begin
          pj_nxt = pj_r + VERT_W'(1);
        end
      end
      ST_LOAD: begin
        state_nxt = ST_ELIM;
        col_nxt   = '0;
      end
      ST_ELIM: begin
        if (col_r == VERT_W'(VERTICES - 1)) begin
          state_nxt = ST_EMIT;
        end else begin
          col_nxt = col_r + VERT_W'(1);
        end
      end
      ST_EMIT: begin
        if (last_sub) begin
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_LOAD;
          sub_nxt   = sub_r + SUBSET_W'(1);
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State and counter registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pi_r    <= '0;
      pj_r    <= '0;
      col_r   <= '0;
      sub_r   <= '0;
    end else begin
      state_r <= state_nxt;
      pi_r    <= pi_nxt;
      pj_r    <= pj_nxt;
      col_r   <= col_nxt;
      sub_r   <= sub_nxt;
    end
  end

  // Commands to the datapath
  always_comb begin
    cmd           = '0;
    cmd.clear_adj = go;
    cmd.gen_step  = (state_r == ST_GEN);
    cmd.pair_i    = pi_r;
    cmd.pair_j    = pj_r;
    cmd.load      = (state_r == ST_LOAD);
    cmd.elim_step = (state_r == ST_ELIM);
    cmd.col       = col_r;
    cmd.subset    = sub_r;
  end

  assign busy               = (state_r != ST_IDLE);
  assign out_valid          = (state_r == ST_EMIT);
  assign out_cut_index      = CUT_W'(sub_r - SUBSET_W'(1));
  assign out_last_of_sample = out_valid && last_sub;

endmodule

@@ hdl/gcrs_dp.sv @@
// Datapath: seed and generator, adjacency rows, column-serial GF(2) elimination.
module gcrs_dp
  import gcrs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  gcrs_cmd_t             cmd,
  input  logic                  cfg_we,
  input  logic [SEED_W-1:0]     cfg_seed_value,
  output logic [OUT_RANK_W-1:0] cut_rank
);

  logic [SEED_W-1:0] gen_r;
  logic [SEED_W-1:0] gen_nxt;
  row_t              adj_r  [VERTICES];
  row_t              elim_r [VERTICES];
  row_t              used_r;
  logic [RANK_W-1:0] rank_r;
  row_t              vmask;
  row_t              hit;
  row_t              piv_oh;
  row_t              piv_row;
  logic              found;

  assign gen_nxt = xs_next(gen_r);

  // Generator state; reset and a seed write load it, a generation step advances it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gen_r  <= SEED_RESET;
    end else if (cfg_we) begin
      gen_r  <= cfg_seed_value;
    end else if (cmd.gen_step) begin
      gen_r  <= gen_nxt;
    end
  end

  // Adjacency rows: cleared per sample, one symmetric edge per step
  always_ff @(posedge clk) begin
    for (int k = 0; k < VERTICES; k++) begin
      if (cmd.clear_adj) begin
        adj_r[k] <= '0;
      end else if (cmd.gen_step) begin
        if (VERT_W'(k) == cmd.pair_i) adj_r[k][cmd.pair_j] <= gen_nxt[0];
        if (VERT_W'(k) == cmd.pair_j) adj_r[k][cmd.pair_i] <= gen_nxt[0];
      end
    end
  end

  // Chosen vertices of the current subset
  for (genvar v = 0; v < VERTICES; v++) begin : g_vmask
    localparam int Blk = v / BLOCK_SIZE;
    if (Blk < NUM_BLOCKS) begin : g_in
      assign vmask[v] = cmd.subset[Blk];
    end else begin : g_out
      assign vmask[v] = 1'b0;
    end
  end

  // Pivot search on the current column among rows not yet used as pivots
  always_comb begin
    for (int k = 0; k < VERTICES; k++) begin
      hit[k] = elim_r[k][cmd.col] && !used_r[k];
    end
    piv_oh  = hit & (~hit + row_t'(1));
    found   = |hit;
    piv_row = '0;
    for (int k = 0; k < VERTICES; k++) begin
      if (piv_oh[k]) piv_row = piv_row | elim_r[k];
    end
  end

  // Elimination rows: rows stay in vertex order, unchosen rows are zero
  always_ff @(posedge clk) begin
    for (int k = 0; k < VERTICES; k++) begin
      if (cmd.load) begin
        elim_r[k] <= vmask[k] ? (adj_r[k] & ~vmask) : '0;
      end else if (cmd.elim_step && found && !piv_oh[k] && elim_r[k][cmd.col]) begin
        elim_r[k] <= elim_r[k] ^ piv_row;
      end
    end
  end

  // Pivot bookkeeping and rank count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
      rank_r <= '0;
    end else if (cmd.load) begin
      used_r <= '0;
      rank_r <= '0;
    end else if (cmd.elim_step && found) begin
      used_r <= used_r | piv_oh;
      rank_r <= rank_r + RANK_W'(1);
    end
  end

  // Saturate to the result width
  assign cut_rank = (int'(rank_r) > OUT_RANK_MAX) ? OUT_RANK_W'(OUT_RANK_MAX)
                                                  : OUT_RANK_W'(rank_r);

endmodule

@@ hdl/graph_cut_rank_sampler.sv @@
// Top level of the graph cut rank sampler: sequencer plus datapath.
//
// Usage:
//   Command channel: a request beat is taken at a clock edge with start high
//   and busy low. A beat with in_sample_request low is taken and ignored.
//   A request draws a random 12-vertex graph from the 64-bit xorshift
//   generator (one step per vertex pair, 66 steps, one per cycle), then
//   emits 31 result beats, one per nonempty subset of vertex blocks 0..4.
//   Result channel: out_valid strobes for one cycle per beat with
//   out_cut_index, out_cut_rank and out_last_of_sample; the receiver cannot
//   stall, so beats must be taken when shown.
//   Sequence: each subset runs a load step, 12 column steps and an emit
//   step; the first beat follows the 66 generator steps. busy stays high
//   through the generator steps and all 31 subsets, so no new request is
//   taken until after the last beat. The column loop of the single
//   elimination unit sets most of the busy time.
//   Configuration: cfg_seed_value is written when cfg_valid and cfg_ready
//   are high; cfg_ready is high while idle. A write also reloads the
//   generator state.
//   Reset (rst_n low, synchronous): idle, seed and generator state = 1.
module graph_cut_rank_sampler
  import gcrs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic                  in_sample_request,
  output logic                  out_valid,
  output logic [CUT_W-1:0]      out_cut_index,
  output logic [OUT_RANK_W-1:0] out_cut_rank,
  output logic                  out_last_of_sample,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [SEED_W-1:0]     cfg_seed_value
);

  gcrs_cmd_t cmd;
  logic      cfg_we;

  assign cfg_ready = !busy;
  assign cfg_we    = cfg_valid && cfg_ready;

  gcrs_ctrl u_ctrl (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .in_sample_request  (in_sample_request),
    .busy               (busy),
    .cmd                (cmd),
    .out_valid          (out_valid),
    .out_cut_index      (out_cut_index),
    .out_last_of_sample (out_last_of_sample)
  );

  gcrs_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .cfg_we         (cfg_we),
    .cfg_seed_value (cfg_seed_value),
    .cut_rank       (out_cut_rank)
  );

endmodule

@@ hdl/gcrs_checker.sv @@
// Port-level checks for the graph cut rank sampler, bound to the top level.
module gcrs_checker
  import gcrs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic                  busy,
  input  logic                  in_sample_request,
  input  logic                  out_valid,
  input  logic [CUT_W-1:0]      out_cut_index,
  input  logic                  out_last_of_sample
);

  // Result beats only while a sample is in progress
  a_beat_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result beat while idle");

  // Result beats are never back to back
  a_beat_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result beats in consecutive cycles");

  // Last beat carries the last subset and frees the block
  a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_of_sample) |-> (out_cut_index == CUT_W'(NUM_SUBSETS - 1)))
    else $error("last beat with wrong cut index");

  a_last_free: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_of_sample) |=> !busy)
    else $error("still busy after last beat");

  // An empty request does not start work
  a_empty_req: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !in_sample_request) |=> !busy)
    else $error("empty request started a sample");

endmodule

bind graph_cut_rank_sampler gcrs_checker u_gcrs_checker (.*);

@@ sim/graph_cut_rank_sampler_test.sv @@
// Self-checking testbench for the graph cut rank sampler: queued request beats, predicted cut ranks.
`timescale 1ns / 1ps

module graph_cut_rank_sampler_test
  import gcrs_pkg::*;
();

  localparam int SETTLE_CYCLES  = 520;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_PHASES  = 6;
  localparam int PHASE_REQUESTS = 25;

  typedef struct packed {
    logic [CUT_W-1:0]      cut_index;
    logic [OUT_RANK_W-1:0] cut_rank;
    logic                  last_of_sample;
  } cut_beat_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic                  in_sample_request = 1'b0;
  logic                  out_valid;
  logic [CUT_W-1:0]      out_cut_index;
  logic [OUT_RANK_W-1:0] out_cut_rank;
  logic                  out_last_of_sample;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [SEED_W-1:0]     cfg_seed_value = '0;

  // Predictor state
  logic [SEED_W-1:0] prng_state;
  row_t              cut_rows [VERTICES];

  // Stimulus and scoreboard
  bit        request_beats [$];
  cut_beat_t expected_cuts [$];
  int        mismatches = 0;
  int        gap_left = 0;
  bit        burst_phase = 1'b0;
  int        quiet_cycles = 0;

  graph_cut_rank_sampler dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_sample_request  (in_sample_request),
    .out_valid          (out_valid),
    .out_cut_index      (out_cut_index),
    .out_cut_rank       (out_cut_rank),
    .out_last_of_sample (out_last_of_sample),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_seed_value     (cfg_seed_value)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Rank over GF(2) of the first n entries of cut_rows, pivoting columns in order
  function automatic int gf2_rank(int n);
    int   r;
    int   piv;
    row_t t;
    r = 0;
    for (int c = 0; c < VERTICES && r < n; c++) begin
      piv = -1;
      for (int i = r; i < n; i++) begin
        if (piv < 0 && cut_rows[i][c]) piv = i;
      end
      if (piv >= 0) begin
        t = cut_rows[r];
        cut_rows[r] = cut_rows[piv];
        cut_rows[piv] = t;
        for (int i = 0; i < n; i++) begin
          if (i != r && cut_rows[i][c]) cut_rows[i] = cut_rows[i] ^ cut_rows[r];
        end
        r++;
      end
    end
    return r;
  endfunction

  // Draw one graph from the generator and queue the 31 cut ranks it yields
  function automatic void draw_sample_cuts();
    row_t      adj [VERTICES];
    row_t      vmask;
    int        n;
    int        rnk;
    cut_beat_t beat;
    foreach (adj[v]) adj[v] = '0;
    for (int i = 0; i < VERTICES; i++) begin
      for (int j = i + 1; j < VERTICES; j++) begin
        prng_state = prng_state ^ (prng_state << XS_A);
        prng_state = prng_state ^ (prng_state >> XS_B);
        prng_state = prng_state ^ (prng_state << XS_C);
        if (prng_state[0]) begin
          adj[i][j] = 1'b1;
          adj[j][i] = 1'b1;
        end
      end
    end
    for (int m = 1; m <= NUM_SUBSETS; m++) begin
      vmask = '0;
      for (int b = 0; b < NUM_BLOCKS; b++) begin
        for (int k = 0; k < BLOCK_SIZE; k++) begin
          // vertices past the end of the graph are dropped
          if (((m >> b) & 1) != 0 && b * BLOCK_SIZE + k < VERTICES)
            vmask[b * BLOCK_SIZE + k] = 1'b1;
        end
      end
      n = 0;
      for (int v = 0; v < VERTICES; v++) begin
        if (vmask[v]) begin
          cut_rows[n] = adj[v] & ~vmask;
          n++;
        end
      end
      rnk = gf2_rank(n);
      if (rnk > OUT_RANK_MAX) rnk = OUT_RANK_MAX;
      beat.cut_index      = CUT_W'(m - 1);
      beat.cut_rank       = OUT_RANK_W'(rnk);
      beat.last_of_sample = (m == NUM_SUBSETS);
      expected_cuts.push_back(beat);
    end
  endfunction

  // Mostly short gaps, a few long enough to land anywhere in a busy period
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(20, 600);
  endfunction

  // Request driver: one beat per handshake, random gaps between beats outside burst phases
  always @(posedge clk) begin : drive_requests
    bit taken;
    bit hold;
    if (!rst_n) begin
      start <= 1'b0;
      in_sample_request <= 1'b0;
      gap_left = 0;
    end else begin
      taken = start && !busy;
      hold  = start && !taken;
      if (taken) begin
        if (request_beats.pop_front()) draw_sample_cuts();
        gap_left = burst_phase ? 0 : pick_gap();
      end else if (!start && gap_left > 0) begin
        gap_left--;
      end
      if (hold || (request_beats.size() > 0 && gap_left == 0)) begin
        start <= 1'b1;
        in_sample_request <= request_beats[0];
      end else begin
        start <= 1'b0;
        in_sample_request <= 1'b0;
      end
    end
  end

  // Result monitor: every strobe is checked against the oldest prediction
  always @(posedge clk) begin : check_results
    cut_beat_t want;
    if (rst_n && out_valid) begin
      if (expected_cuts.size() == 0) begin
        $error("unexpected result beat: cut_index %0d cut_rank %0d last_of_sample %0b",
               out_cut_index, out_cut_rank, out_last_of_sample);
        mismatches++;
      end else begin
        want = expected_cuts.pop_front();
        if (out_cut_index !== want.cut_index) begin
          $error("cut_index: expected %0d, got %0d", want.cut_index, out_cut_index);
          mismatches++;
        end
        if (out_cut_rank !== want.cut_rank) begin
          $error("cut_rank: expected %0d, got %0d", want.cut_rank, out_cut_rank);
          mismatches++;
        end
        if (out_last_of_sample !== want.last_of_sample) begin
          $error("last_of_sample: expected %0b, got %0b",
                 want.last_of_sample, out_last_of_sample);
          mismatches++;
        end
      end
    end
  end

  // Watchdog on cycles where no beat moves on any channel
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("graph_cut_rank_sampler_test: FAIL");
      $finish;
    end
  end

  // Seed write through the config channel; predictor follows on the handshake
  task automatic load_seed(input logic [SEED_W-1:0] value);
    @(posedge clk);
    repeat ($urandom_range(0, 5)) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_seed_value <= value;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    prng_state = value;
    cfg_valid <= 1'b0;
  endtask

  // Wait until every queued beat is taken and every result has come back,
  // then give a dropped beat time to clear the block
  task automatic wait_drained();
    while (request_beats.size() > 0 || start || expected_cuts.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Requests with random dropped beats mixed in
  task automatic queue_samples(input int count);
    int queued;
    queued = 0;
    while (queued < count) begin
      if ($urandom_range(0, 9) == 0) begin
        request_beats.push_back(1'b0);
      end else begin
        request_beats.push_back(1'b1);
        queued++;
      end
    end
  endtask

  initial begin
    logic [SEED_W-1:0] seed;
    prng_state = SEED_RESET;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Reset seed, with dropped beats in between
    request_beats = '{1'b1, 1'b0, 1'b1, 1'b1};
    wait_drained();

    // Zero seed: empty graphs, every rank zero
    load_seed('0);
    request_beats = '{1'b1, 1'b0, 1'b1};
    wait_drained();

    // All-ones seed, then top bit only
    load_seed('1);
    burst_phase = 1'b1;
    request_beats = '{1'b1, 1'b1, 1'b0, 1'b1};
    wait_drained();
    burst_phase = 1'b0;
    load_seed({1'b1, {(SEED_W - 1){1'b0}}});
    request_beats = '{1'b1, 1'b1};
    wait_drained();

    // Random seeds, each phase a fresh stream of samples
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case ($urandom_range(0, 3))
        0: seed = SEED_W'(1) << $urandom_range(0, SEED_W - 1);
        1: seed = SEED_W'($urandom_range(1, 255));
        default: seed = {$urandom, $urandom};
      endcase
      load_seed(seed);
      burst_phase = ($urandom_range(0, 3) == 0);
      queue_samples(PHASE_REQUESTS);
      wait_drained();
    end

    if (mismatches == 0 && expected_cuts.size() == 0) begin
      $display("graph_cut_rank_sampler_test: PASS");
    end else begin
      $display("graph_cut_rank_sampler_test: FAIL");
    end
    $finish;
  end

endmodule
